FILE: hw/rtl/address_pool_session_table_defines.svh
// ----------------------------------------------------------------------------
// address_pool_session_table_defines.svh
// Assertion macros used by the session table RTL.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_POOL_SESSION_TABLE_DEFINES_SVH
`define ADDRESS_POOL_SESSION_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define APST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/apst_pkg.sv
// ----------------------------------------------------------------------------
// apst_pkg
// Types, codes and constants of the address pool session table.
// ----------------------------------------------------------------------------
package apst_pkg;

    localparam int SLOTS_DEF = 32;
    localparam int MAX_OUT   = 32;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);

    localparam int KEY_W  = 16;
    localparam int ADDR_W = 32;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_END     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd2;

    localparam logic [ADDR_W-1:0] POOL_START_RST   = 32'h0A08_0002;
    localparam logic [ADDR_W-1:0] POOL_END_RST     = 32'h0A08_00FE;
    localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RST = 32'd300;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_TOUCH   = 2'd2,
        OP_AGE     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EXPIRED  = 3'd3,
        ST_NONE     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] address;
        logic [KEY_W-1:0]  entry_key;
        logic [4:0]        slot;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]  owner;
        logic [ADDR_W-1:0] address;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [ADDR_W-1:0] pool_start;
        logic [ADDR_W-1:0] pool_end;
        logic [TIME_W-1:0] idle_timeout;
        logic [ADDR_W-1:0] next_address;
    } t_cfg;

endpackage

FILE: hw/rtl/apst_mem.sv
// ----------------------------------------------------------------------------
// apst_mem
// Slot entry RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module apst_mem #(
    parameter int SLOTS = apst_pkg::SLOTS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic            i_clk,
    input  logic [IW-1:0]   i_rd_addr,
    output apst_pkg::t_entry o_rdata,
    input  logic            i_wr_en,
    input  logic [IW-1:0]   i_wr_addr,
    input  apst_pkg::t_entry i_wr_data
);
    import apst_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_rd_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/apst_cfg.sv
// ----------------------------------------------------------------------------
// apst_cfg
// Configuration registers and the rotating pool address counter.
// ----------------------------------------------------------------------------
module apst_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [apst_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [apst_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_adv,
    output apst_pkg::t_cfg                      o_cfg
);
    import apst_pkg::*;

    t_cfg              r_cfg;
    logic [ADDR_W:0]   inc;

    // counter step, taken one bit wider so the top address does not wrap
    assign inc = {1'b0, r_cfg.next_address} + {{ADDR_W{1'b0}}, 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool_start   <= POOL_START_RST;
            r_cfg.pool_end     <= POOL_END_RST;
            r_cfg.idle_timeout <= IDLE_TIMEOUT_RST;
            r_cfg.next_address <= POOL_START_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POOL_START: begin
                    r_cfg.pool_start   <= i_cfg_wdata;
                    r_cfg.next_address <= i_cfg_wdata;
                end
                CFG_POOL_END: begin
                    r_cfg.pool_end <= i_cfg_wdata;
                end
                CFG_IDLE_TIMEOUT: begin
                    r_cfg.idle_timeout <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end else if (i_adv) begin
            if (inc > {1'b0, r_cfg.pool_end}) begin
                r_cfg.next_address <= r_cfg.pool_start;
            end else begin
                r_cfg.next_address <= inc[ADDR_W-1:0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/apst_ctrl.sv
// ----------------------------------------------------------------------------
// apst_ctrl
// Scan sequencer: walks the slot RAM one entry a cycle unless an age scan
// stalls, updates the hit entry, keeps slot valid bits and drives the result register.
// ----------------------------------------------------------------------------
`include "address_pool_session_table_defines.svh"

module apst_ctrl #(
    parameter int SLOTS = apst_pkg::SLOTS_DEF,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  apst_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output apst_pkg::t_out_item  o_out_item,
    input  apst_pkg::t_cfg       i_cfg,
    output logic                 o_adv,
    output logic [IW-1:0]        o_rd_addr,
    input  apst_pkg::t_entry     i_rdata,
    output logic                 o_wr_en,
    output logic [IW-1:0]        o_wr_addr,
    output apst_pkg::t_entry     o_wr_data
);
    import apst_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);

    t_state             r_state, n_state;
    t_op                r_op;
    logic [KEY_W-1:0]   r_key;
    logic [TIME_W-1:0]  r_now;
    logic [CW-1:0]      r_idx;
    logic [IW-1:0]      r_didx;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pend_v;
    t_out_item          r_pend;
    t_out_item          r_fin;
    t_out_item          r_out;
    logic               r_ov;
    logic [SLOTS-1:0]   r_valid;

    logic               occ, expired, is_age, hit, last_chk, emit_ok;
    logic               in_scan, stall, age_cap, scan_end, accept, key_zero;
    logic [TIME_W-1:0]  idle_time;
    logic               set_v, clr_v, emit, fin_ld, pend_ld;
    t_out_item          emit_item, fin_item, cur_exp;

    // decisions on the entry returned by the RAM this cycle
    always_comb begin
        occ       = r_valid[r_didx];
        idle_time = r_now - i_rdata.stamp;
        expired   = occ && (idle_time > i_cfg.idle_timeout);
        is_age    = (r_op == OP_AGE);
        if (r_op == OP_ALLOC) begin
            hit = !occ;
        end else begin
            hit = occ && (i_rdata.owner == r_key);
        end
        last_chk = (r_didx == IW'(SLOTS - 1));
        emit_ok  = !r_ov || i_out_ready;
        in_scan  = (r_state == S_SCAN);
        // an older expiry still pending must leave before a new one takes its place
        stall    = in_scan && is_age && expired && r_pend_v && !emit_ok;
        age_cap  = expired && (r_cnt == CNT_W'(MAX_OUT - 1));
        scan_end = in_scan && !stall &&
                   (is_age ? (last_chk || age_cap) : (hit || last_chk));
        accept   = i_in_valid && (r_state == S_IDLE);
        key_zero = (i_in_item.key == '0) && (t_op'(i_in_item.op) != OP_AGE);
        cur_exp  = '{status: ST_EXPIRED, address: i_rdata.address,
                     entry_key: i_rdata.owner, slot: 5'(r_didx), last: 1'b0};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = key_zero ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_wr_en    = 1'b0;
        o_wr_addr  = r_didx;
        o_wr_data  = i_rdata;
        o_adv      = 1'b0;
        set_v      = 1'b0;
        clr_v      = 1'b0;
        emit       = 1'b0;
        emit_item  = r_fin;
        fin_ld     = 1'b0;
        fin_item   = '{status: ST_NOTFOUND, address: '0, entry_key: '0,
                       slot: '0, last: 1'b1};
        pend_ld    = 1'b0;
        o_rd_addr  = (stall || scan_end) ? r_didx : r_idx[IW-1:0];
        case (r_state)
            S_IDLE: begin
                o_rd_addr = '0;
                fin_ld    = accept && key_zero;
            end
            S_SCAN: begin
                if (!is_age) begin
                    if (hit) begin
                        fin_ld   = 1'b1;
                        fin_item = '{status: ST_OK, address: i_rdata.address,
                                     entry_key: r_key, slot: 5'(r_didx), last: 1'b1};
                        case (r_op)
                            OP_ALLOC: begin
                                o_wr_en   = 1'b1;
                                o_wr_data = '{owner: r_key,
                                              address: i_cfg.next_address,
                                              stamp: r_now};
                                set_v     = 1'b1;
                                o_adv     = 1'b1;
                                fin_item.address = i_cfg.next_address;
                            end
                            OP_RELEASE: begin
                                clr_v = 1'b1;
                            end
                            default: begin
                                o_wr_en         = 1'b1;
                                o_wr_data.stamp = r_now;
                            end
                        endcase
                    end else if (last_chk) begin
                        fin_ld = 1'b1;
                        if (r_op == OP_ALLOC) begin
                            fin_item.status = ST_FULL;
                        end
                    end
                end else if (!stall) begin
                    if (expired) begin
                        clr_v = 1'b1;
                        if (r_pend_v) begin
                            emit      = 1'b1;
                            emit_item = r_pend;
                        end
                        if (scan_end) begin
                            fin_ld        = 1'b1;
                            fin_item      = cur_exp;
                            fin_item.last = 1'b1;
                        end else begin
                            pend_ld = 1'b1;
                        end
                    end else if (scan_end) begin
                        fin_ld = 1'b1;
                        if (r_pend_v) begin
                            fin_item      = r_pend;
                            fin_item.last = 1'b1;
                        end else begin
                            fin_item.status = ST_NONE;
                        end
                    end
                end
            end
            S_FIN: begin
                emit = emit_ok;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_pend_v <= 1'b0;
                r_cnt    <= '0;
            end else if (pend_ld) begin
                r_pend_v <= 1'b1;
                r_cnt    <= r_cnt + CNT_W'(1);
            end
            if (set_v) begin
                r_valid[r_didx] <= 1'b1;
            end else if (clr_v) begin
                r_valid[r_didx] <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_in_item.op);
            r_key  <= i_in_item.key;
            r_now  <= i_in_item.now;
            r_idx  <= CW'(1);
            r_didx <= '0;
        end else if (in_scan && !stall && !scan_end) begin
            r_idx  <= r_idx + CW'(1);
            r_didx <= r_idx[IW-1:0];
        end
        if (pend_ld) begin
            r_pend <= cur_exp;
        end
        if (fin_ld) begin
            r_fin <= fin_item;
        end
        if (emit) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    `APST_ASSERT_IMP(a_pend_only_age, i_clk, i_rst_n, r_pend_v, r_op == OP_AGE, "pending expiry outside age scan")
    `APST_ASSERT_IMP(a_scan_index, i_clk, i_rst_n, r_state == S_SCAN, r_idx == CW'(r_didx) + CW'(1), "read index out of step with check index")
    `APST_ASSERT_NXT(a_alloc_valid, i_clk, i_rst_n, o_wr_en && (r_op == OP_ALLOC), r_valid[$past(r_didx)], "allocated slot not marked valid")

endmodule

FILE: hw/rtl/address_pool_session_table.sv
// Operation: allocate, release and touch scan the slots up to the first slot hit
//   (the last slot when none); a zero key answers without a scan.
// Items: a new item is taken only once the last result is in the output register;
//   the slot RAM scan checks one entry per cycle; age scans stall while expiries back up.
// Reset: synchronous, active low; all slots free, registers at their defaults.
// ----------------------------------------------------------------------------
// address_pool_session_table
// Session table with a rotating address pool and idle aging. Entries live in
// one RAM {owner, address, stamp}; occupancy is kept in per-slot valid flops.
// ----------------------------------------------------------------------------
module address_pool_session_table #(
    parameter int SLOTS = apst_pkg::SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input item channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  apst_pkg::t_in_item              i_in_item,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output apst_pkg::t_out_item             o_out_item,
    // register writes
    input  logic                            i_cfg_we,
    input  logic [apst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [apst_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import apst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_cfg          cfg;
    logic          adv;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;
    t_entry        rdata;
    t_entry        wr_data;

    // pool_start, pool_end, idle_timeout and the next address to hand out
    apst_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (adv),
        .o_cfg       (cfg)
    );

    // Slot entries. Contents are meaningful only where the valid flop is set,
    // so the RAM needs no clearing after reset. Every write lands before the next
    // read of that slot whose data is used, so no forwarding is needed.
    apst_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rdata   (rdata),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // Sequencer: reads slot 0 in the accept cycle, then checks one slot per cycle unless
    // an age scan stalls; alloc/release/touch stop at the first hit, age walks all slots
    // or stops at MAX_OUT expiries, holding each back one step so the final one can carry last.
    apst_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg       (cfg),
        .o_adv       (adv),
        .o_rd_addr   (rd_addr),
        .i_rdata     (rdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

endmodule
